### src/cqs_pkg.sv
// cqs_pkg: operation and status codes, field widths and stream packing
// for the circular queue with search. no dependencies.
package cqs_pkg;

  // field widths
  localparam int OP_W     = 2;
  localparam int WORD_W   = 32;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 5;
  localparam int QLEN_W   = 5;

  // stream widths, padded to whole bytes
  localparam int IN_FIELDS_W  = OP_W + WORD_W;
  localparam int OUT_FIELDS_W = STATUS_W + WORD_W + POS_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int IN_PAD_W     = IN_TDATA_W - IN_FIELDS_W;
  localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

  // reset value of the length register
  localparam logic [QLEN_W-1:0] QLEN_RESET = 5'd16;

  typedef logic [OP_W-1:0]     op_t;
  typedef logic [STATUS_W-1:0] status_t;

  // operation codes
  localparam op_t OP_ENQ    = 2'd0;
  localparam op_t OP_DEQ    = 2'd1;
  localparam op_t OP_SEARCH = 2'd2;

  // status codes
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_FULL     = 2'd1;
  localparam status_t ST_EMPTY    = 2'd2;
  localparam status_t ST_NOTFOUND = 2'd3;

endpackage

### src/cqs_ram.sv
// cqs_ram: generic single-write, single-read synchronous ram with a
// registered read port. no dependencies.
module cqs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/circular_queue_with_search.sv
// circular_queue_with_search: top level of a circular queue of signed words
// with enqueue, dequeue and linear search. depends on cqs_pkg and cqs_ram.
//
//   channel   dir  handshake          payload
//   s_axis    in   tvalid / tready    tdata: op[1:0], value[33:2], zero pad
//   m_axis    out  tvalid / tready    tdata: status[1:0], data[33:2],
//                                            position[38:34], zero pad
//   cfg       in   cfg_wr_en          cfg_wr_data: queue_length
//
// enqueue, unused op and any empty or full report: answered from idle as the
//   transaction is taken; dequeue: answered from the read state with the word
//   from the registered ram read; search: one slot compared per cycle through the
//   single ram read port, walking from head toward tail
// rst clears head and tail, sets the empty flag and sets queue_length to 16; the
//   slot ram is not cleared, a slot is only read after it was written
// a new transaction is taken only in idle and only when the result register
//   is free or being drained in the same cycle; m_axis stalls hold the result
module circular_queue_with_search #(
  parameter int DEPTH = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  // slave stream: op[1:0], value[33:2], pad above
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [cqs_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // master stream: status[1:0], data[33:2], position[38:34], pad above
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [cqs_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // length register write
  input  logic                               cfg_wr_en,
  input  logic [cqs_pkg::QLEN_W-1:0]         cfg_wr_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int LW = $clog2(DEPTH + 1);
  // compare width for indices against the length
  localparam int CW = (LW > cqs_pkg::QLEN_W) ? LW : cqs_pkg::QLEN_W;

  // control states
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_READ   = 2'd1;
  localparam logic [1:0] S_SEARCH = 2'd2;

  logic [1:0] state;

  // queue control registers
  logic [cqs_pkg::QLEN_W-1:0] queue_length;
  logic [AW-1:0]              head;
  logic [AW-1:0]              tail;
  logic                       is_empty;

  // search walk registers
  logic [AW-1:0]                   cur;     // next slot to read
  logic [AW-1:0]                   stop;    // slot after tail
  logic [AW-1:0]                   step;    // offset from head of the slot under compare
  logic                            last;    // slot under compare ends the walk
  logic signed [cqs_pkg::WORD_W-1:0] key;

  // result register
  logic                                out_valid;
  logic                                out_load;
  cqs_pkg::status_t                    out_status;
  logic signed [cqs_pkg::WORD_W-1:0]   out_data;
  logic [cqs_pkg::POS_W-1:0]           out_pos;

  // unpacked input fields
  cqs_pkg::op_t                        in_op;
  logic signed [cqs_pkg::WORD_W-1:0]   in_value;

  // ram ports
  logic                            ram_we;
  logic [AW-1:0]                   ram_waddr;
  logic [AW-1:0]                   ram_raddr;
  logic [cqs_pkg::WORD_W-1:0]      ram_rdata;

  logic          s_fire;
  logic [CW-1:0] eff_len;
  logic [AW-1:0] tail_adv;
  logic [AW-1:0] head_adv;
  logic [AW-1:0] cur_adv;
  logic          full;

  assign in_op    = s_axis_tdata[cqs_pkg::OP_W-1:0];
  assign in_value = s_axis_tdata[cqs_pkg::OP_W +: cqs_pkg::WORD_W];

  // length clamped to 1..DEPTH
  always_comb begin
    eff_len = CW'(queue_length);
    if (eff_len == '0) begin
      eff_len = CW'(1);
    end else if (eff_len > CW'(DEPTH)) begin
      eff_len = CW'(DEPTH);
    end
  end

  // step an index, wrapping at the length in use
  function automatic logic [AW-1:0] advance(input logic [AW-1:0] i,
                                            input logic [CW-1:0] len);
    logic [CW-1:0] n;
    n = CW'(i) + CW'(1);
    return (n >= len) ? '0 : AW'(n);
  endfunction

  assign tail_adv = advance(tail, eff_len);
  assign head_adv = advance(head, eff_len);
  assign cur_adv  = advance(cur, eff_len);
  assign full     = !is_empty && (tail_adv == head);

  // take a transaction only in idle with the result register free or draining
  assign s_axis_tready = (state == S_IDLE) && (!out_valid || m_axis_tready);
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  // enqueue writes in idle only, where the read port reads the head, so an enqueue
  // into an empty queue reads and writes slot 0 in the same cycle
  assign ram_we    = s_fire && (in_op == cqs_pkg::OP_ENQ) && !full;
  assign ram_waddr = is_empty ? '0 : tail_adv;
  // idle reads the head for dequeue and the first search compare
  assign ram_raddr = (state == S_SEARCH) ? cur : head;

  cqs_ram #(
    .WIDTH (cqs_pkg::WORD_W),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // length register
  always_ff @(posedge clk) begin
    if (rst) begin
      queue_length <= cqs_pkg::QLEN_RESET;
    end else if (cfg_wr_en) begin
      queue_length <= cfg_wr_data;
    end
  end

  // a result enters the output register this cycle
  always_comb begin
    out_load = 1'b0;
    unique case (state)
      S_IDLE: begin
        // dequeue and search on a non-empty queue answer later
        out_load = s_fire && !(((in_op == cqs_pkg::OP_DEQ) ||
                                (in_op == cqs_pkg::OP_SEARCH)) && !is_empty);
      end
      S_READ: begin
        out_load = 1'b1;
      end
      S_SEARCH: begin
        out_load = (ram_rdata == key) || last;
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  // result valid flag, held until drained
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  // control and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      tail      <= '0;
      is_empty  <= 1'b1;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_fire) begin
            case (in_op)
              cqs_pkg::OP_ENQ: begin
                out_data   <= '0;
                out_pos    <= '0;
                out_status <= full ? cqs_pkg::ST_FULL : cqs_pkg::ST_OK;
                if (is_empty) begin
                  // first word always lands in slot 0
                  head     <= '0;
                  tail     <= '0;
                  is_empty <= 1'b0;
                end else if (!full) begin
                  tail <= tail_adv;
                end
              end
              cqs_pkg::OP_DEQ: begin
                if (is_empty) begin
                  out_status <= cqs_pkg::ST_EMPTY;
                  out_data   <= '0;
                  out_pos    <= '0;
                end else begin
                  // head word is on its way out of the ram
                  state <= S_READ;
                  if (head == tail) begin
                    head     <= '0;
                    tail     <= '0;
                    is_empty <= 1'b1;
                  end else begin
                    head <= head_adv;
                  end
                end
              end
              cqs_pkg::OP_SEARCH: begin
                if (is_empty) begin
                  out_status <= cqs_pkg::ST_EMPTY;
                  out_data   <= '0;
                  out_pos    <= '0;
                end else begin
                  state <= S_SEARCH;
                  key   <= in_value;
                  cur   <= head_adv;
                  stop  <= tail_adv;
                  step  <= '0;
                  last  <= (head_adv == tail_adv);
                end
              end
              default: begin
                // unused op: no state change, all-zero result
                out_status <= cqs_pkg::ST_OK;
                out_data   <= '0;
                out_pos    <= '0;
              end
            endcase
          end
        end
        S_READ: begin
          out_status <= cqs_pkg::ST_OK;
          out_data   <= ram_rdata;
          out_pos    <= '0;
          state      <= S_IDLE;
        end
        S_SEARCH: begin
          // compare the slot read last cycle while reading the next one
          if (ram_rdata == key) begin
            out_status <= cqs_pkg::ST_OK;
            out_data   <= '0;
            out_pos    <= cqs_pkg::POS_W'({1'b0, step} + (AW + 1)'(1));
            state      <= S_IDLE;
          end else if (last) begin
            out_status <= cqs_pkg::ST_NOTFOUND;
            out_data   <= '0;
            out_pos    <= '0;
            state      <= S_IDLE;
          end else begin
            cur  <= cur_adv;
            step <= step + AW'(1);
            // walk ends with the tail slot or after DEPTH compares
            last <= (cur_adv == stop) || (step == AW'(DEPTH - 2));
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{cqs_pkg::OUT_PAD_W{1'b0}}, out_pos, out_data, out_status};

endmodule

### src/cqs_checker.sv
// cqs_checker: port-level checks for circular_queue_with_search and the
// bind that attaches them. depends on cqs_pkg.
module cqs_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [cqs_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  logic [cqs_pkg::STATUS_W-1:0] st;
  logic [cqs_pkg::WORD_W-1:0]   dat;
  logic [cqs_pkg::POS_W-1:0]    pos;

  assign st  = m_axis_tdata[cqs_pkg::STATUS_W-1:0];
  assign dat = m_axis_tdata[cqs_pkg::STATUS_W +: cqs_pkg::WORD_W];
  assign pos = m_axis_tdata[cqs_pkg::STATUS_W + cqs_pkg::WORD_W +: cqs_pkg::POS_W];

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // no new transaction while a result is stuck
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !(m_axis_tvalid && !m_axis_tready))
    else $error("input taken while result stalled");

  // any failure status carries no word and no position
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (st != cqs_pkg::ST_OK) |-> (dat == '0) && (pos == '0))
    else $error("failure status with nonzero payload");

  // a match position never comes with a dequeued word
  a_pos_xor_data: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (pos != '0) |-> (st == cqs_pkg::ST_OK) && (dat == '0))
    else $error("match position with bad status or data");

endmodule

bind circular_queue_with_search cqs_checker u_cqs_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
